// ===== src/gdo_pkg.sv =====
// Shared types, constants and calendar functions for the date offset block.
package gdo_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 12;
    localparam int CENT_W  = 7;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_DIV   = 14'd100;
    localparam logic [CENT_W-1:0]  CENT_LAST  = 7'd99;

    // 2^19 / 100 rounded up: floor(y * RECIP_100 / 2^19) == y / 100 for y below 43690
    localparam int                 RECIP_W     = 13;
    localparam int                 RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;

    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR  = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN  = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV  = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [DAY_W-1:0]   LEN_31     = 5'd31;
    localparam logic [DAY_W-1:0]   LEN_30     = 5'd30;
    localparam logic [DAY_W-1:0]   LEN_29     = 5'd29;
    localparam logic [DAY_W-1:0]   LEN_28     = 5'd28;

    typedef struct packed {
        logic               func;
        logic [DAY_W-1:0]   day_in;
        logic [MONTH_W-1:0] month_in;
        logic [YEAR_W-1:0]  year_in;
        logic [COUNT_W-1:0] day_count;
    } gdo_in_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day_out;
        logic [MONTH_W-1:0] month_out;
        logic [YEAR_W-1:0]  year_out;
        logic               input_legal;
        logic               range_error;
    } gdo_out_t;

    // Working date: year kept both whole and split as century / year-of-century
    typedef struct packed {
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        logic [CENT_W-1:0]  q;
        logic [CENT_W-1:0]  r;
    } gdo_date_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_CLAMP,
        ST_WALK
    } gdo_state_t;

    // Leap year from year = 100*q + r
    function automatic logic leap_year(input logic [CENT_W-1:0] q,
                                       input logic [CENT_W-1:0] r);
        logic leap;
        if (r != '0)
            leap = (r[1:0] == 2'b00);
        else
            leap = (q[1:0] == 2'b00);
        return leap;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_FEB: len = leap ? LEN_29 : LEN_28;
            MONTH_APR: len = LEN_30;
            MONTH_JUN: len = LEN_30;
            MONTH_SEP: len = LEN_30;
            MONTH_NOV: len = LEN_30;
            default:   len = LEN_31;
        endcase
        return len;
    endfunction

endpackage

// ===== src/gdo_year_split.sv =====
// Year split by 100 through a reciprocal multiply: century and year-of-century.
module gdo_year_split
    import gdo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [YEAR_W-1:0]   year,
    output logic                done,
    output logic [CENT_W-1:0]   cent,
    output logic [CENT_W-1:0]   yoc
);

    localparam int PROD_W = YEAR_W + RECIP_W;

    logic [YEAR_W-1:0] year_reg, year_next;
    logic [CENT_W-1:0] quo_reg, quo_next;
    logic [CENT_W-1:0] yoc_reg, yoc_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] prod;
    logic [CENT_W-1:0] quo;
    logic [YEAR_W-1:0] rest;

    always_comb
    begin
        prod      = PROD_W'(year_reg) * PROD_W'(RECIP_100);
        quo       = prod[RECIP_SHIFT +: CENT_W];
        rest      = year_reg - YEAR_W'(quo) * YEAR_DIV;
        year_next = year_reg;
        quo_next  = quo_reg;
        yoc_next  = yoc_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            year_next = year;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            // hold century and remainder until the next start
            quo_next  = quo;
            yoc_next  = rest[CENT_W-1:0];
            run_next  = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg <= year_next;
        quo_reg  <= quo_next;
        yoc_reg  <= yoc_next;
    end

    assign done = done_reg;
    assign cent = quo_reg;
    assign yoc  = yoc_reg;

endmodule

// ===== src/gdo_walk_step.sv =====
// One month step of the date walk, forward or backward.
module gdo_walk_step
    import gdo_pkg::*;
#(
    parameter int OFFSET_BITS = 12
)
(
    input  logic                   func,
    input  gdo_date_t              date_cur,
    input  logic [OFFSET_BITS-1:0] cnt_cur,
    output gdo_date_t              date_nxt,
    output logic [OFFSET_BITS-1:0] cnt_nxt,
    output logic                   sat
);

    localparam int CMP_W = (OFFSET_BITS > DAY_W + 1) ? OFFSET_BITS : DAY_W + 1;

    logic [DAY_W-1:0] len;
    logic [DAY_W:0]   rem;
    logic             fits;

    always_comb
    begin
        len      = month_len(date_cur.m, leap_year(date_cur.q, date_cur.r));
        rem      = {1'b0, len} - {1'b0, date_cur.d} + (DAY_W+1)'(1);
        date_nxt = date_cur;
        cnt_nxt  = cnt_cur;
        sat      = 1'b0;
        fits     = 1'b0;
        if (!func)
        begin
            fits = CMP_W'(cnt_cur) < CMP_W'(rem);
            if (fits)
            begin
                date_nxt.d = date_cur.d + DAY_W'(cnt_cur);
                cnt_nxt    = '0;
            end
            else
            begin
                // jump to the first of next month
                cnt_nxt    = cnt_cur - OFFSET_BITS'(rem);
                date_nxt.d = DAY_FIRST;
                if (date_cur.m == MONTH_DEC)
                begin
                    if (date_cur.y == YEAR_MAX)
                    begin
                        date_nxt.d = LEN_31;
                        date_nxt.m = MONTH_DEC;
                        cnt_nxt    = '0;
                        sat        = 1'b1;
                    end
                    else
                    begin
                        date_nxt.m = MONTH_JAN;
                        date_nxt.y = date_cur.y + YEAR_W'(1);
                        if (date_cur.r == CENT_LAST)
                        begin
                            date_nxt.r = '0;
                            date_nxt.q = date_cur.q + CENT_W'(1);
                        end
                        else
                        begin
                            date_nxt.r = date_cur.r + CENT_W'(1);
                        end
                    end
                end
                else
                begin
                    date_nxt.m = date_cur.m + MONTH_W'(1);
                end
            end
        end
        else
        begin
            fits = CMP_W'(cnt_cur) < CMP_W'(date_cur.d);
            if (fits)
            begin
                date_nxt.d = date_cur.d - DAY_W'(cnt_cur);
                cnt_nxt    = '0;
            end
            else
            begin
                // drop to the last day of the previous month
                cnt_nxt = cnt_cur - OFFSET_BITS'(date_cur.d);
                if (date_cur.m != MONTH_JAN)
                begin
                    date_nxt.m = date_cur.m - MONTH_W'(1);
                    date_nxt.d = month_len(date_cur.m - MONTH_W'(1),
                                           leap_year(date_cur.q, date_cur.r));
                end
                else if (date_cur.y == YEAR_MIN)
                begin
                    date_nxt.d = DAY_FIRST;
                    date_nxt.m = MONTH_JAN;
                    cnt_nxt    = '0;
                    sat        = 1'b1;
                end
                else
                begin
                    date_nxt.m = MONTH_DEC;
                    date_nxt.d = LEN_31;
                    date_nxt.y = date_cur.y - YEAR_W'(1);
                    if (date_cur.r == '0)
                    begin
                        date_nxt.r = CENT_LAST;
                        date_nxt.q = date_cur.q - CENT_W'(1);
                    end
                    else
                    begin
                        date_nxt.r = date_cur.r - CENT_W'(1);
                    end
                end
            end
        end
    end

endmodule

// ===== src/gregorian_date_offset.sv =====
// Top level: moves a Gregorian date forward or backward by a day count.
//
// Usage: drive date_in and raise start; the item is taken at the clock edge
// where start is high and busy is low. busy stays high while the item is
// worked on. The result appears on result for exactly one cycle with
// result_valid high; the receiver cannot stall it and must take it then.
// busy is already low in that cycle, so the next item may be taken at the
// same edge the result is delivered.
//
// Sequence: clamp and load, then the year split (load, then a reciprocal
// multiply by 1/100 and a subtract), then clamp the day, then walk month
// by month and finish with the result.
// The month walk loop, one step of the shared month-step unit per cycle,
// dominates the total run time.
//
// Reset: asynchronous, active low; clears the sequencer and the result
// strobe. No storage needs clearing.
module gregorian_date_offset
    import gdo_pkg::*;
#(
    parameter int OFFSET_BITS = 12
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  gdo_in_t  date_in,
    output logic     result_valid,
    output gdo_out_t result
);

    gdo_state_t              state_reg, state_next;
    gdo_date_t               date_reg, date_next;
    logic [OFFSET_BITS-1:0]  cnt_reg, cnt_next;
    logic                    func_reg, func_next;
    logic                    legal_reg, legal_next;
    logic                    err_reg, err_next;
    logic                    valid_reg, valid_next;
    gdo_out_t                result_reg, result_next;

    logic                    accept;
    logic [MONTH_W-1:0]      m_clamp;
    logic [YEAR_W-1:0]       y_clamp;
    logic                    legal_load;
    logic                    split_done;
    logic [CENT_W-1:0]       split_q;
    logic [CENT_W-1:0]       split_r;
    logic [DAY_W-1:0]        len_clamp;
    gdo_date_t               step_date;
    logic [OFFSET_BITS-1:0]  step_cnt;
    logic                    step_sat;

    assign accept = start && (state_reg == ST_IDLE);

    // Clamp month and year at load; the day is clamped once the leap year is known
    always_comb
    begin
        m_clamp = date_in.month_in;
        if (date_in.month_in == '0)
            m_clamp = MONTH_JAN;
        else if (date_in.month_in > MONTH_DEC)
            m_clamp = MONTH_DEC;
        y_clamp = date_in.year_in;
        if (date_in.year_in < YEAR_MIN)
            y_clamp = YEAR_MIN;
        else if (date_in.year_in > YEAR_MAX)
            y_clamp = YEAR_MAX;
        legal_load = !((date_in.year_in < YEAR_MIN) || (date_in.year_in > YEAR_MAX) ||
                       (date_in.month_in == '0) || (date_in.month_in > MONTH_DEC) ||
                       (date_in.day_in == '0));
    end

    gdo_year_split u_split
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .year  (y_clamp),
        .done  (split_done),
        .cent  (split_q),
        .yoc   (split_r)
    );

    gdo_walk_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step
    (
        .func     (func_reg),
        .date_cur (date_reg),
        .cnt_cur  (cnt_reg),
        .date_nxt (step_date),
        .cnt_nxt  (step_cnt),
        .sat      (step_sat)
    );

    assign len_clamp = month_len(date_reg.m, leap_year(split_q, split_r));

    always_comb
    begin
        state_next  = state_reg;
        date_next   = date_reg;
        cnt_next    = cnt_reg;
        func_next   = func_reg;
        legal_next  = legal_reg;
        err_next    = err_reg;
        valid_next  = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    date_next.d = date_in.day_in;
                    date_next.m = m_clamp;
                    date_next.y = y_clamp;
                    cnt_next    = OFFSET_BITS'(date_in.day_count);
                    func_next   = date_in.func;
                    legal_next  = legal_load;
                    err_next    = 1'b0;
                    state_next  = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                // hold until the century split is ready
                if (split_done)
                begin
                    date_next.q = split_q;
                    date_next.r = split_r;
                    state_next  = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                if (date_reg.d > len_clamp)
                begin
                    legal_next  = 1'b0;
                    date_next.d = len_clamp;
                end
                else if (date_reg.d == '0)
                begin
                    date_next.d = DAY_FIRST;
                end
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (cnt_reg == '0)
                begin
                    result_next.day_out     = date_reg.d;
                    result_next.month_out   = date_reg.m;
                    result_next.year_out    = date_reg.y;
                    result_next.input_legal = legal_reg;
                    result_next.range_error = err_reg;
                    valid_next              = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    // advance one month or finish inside the current one
                    date_next = step_date;
                    cnt_next  = step_cnt;
                    err_next  = err_reg || step_sat;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        date_reg   <= date_next;
        cnt_reg    <= cnt_next;
        func_reg   <= func_next;
        legal_reg  <= legal_next;
        err_reg    <= err_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    // A taken item makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item accepted but block not busy");

    // The result strobe lasts a single cycle
    a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");

    // Results carry a real month and day
    a_result_month: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.month_out >= MONTH_JAN) && (result.month_out <= MONTH_DEC) &&
                         (result.day_out != '0))
        else $error("result month or day out of range");

    // A saturated result sits on one of the two calendar ends
    a_sat_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.range_error |->
            ((result.day_out == DAY_FIRST) && (result.month_out == MONTH_JAN) &&
             (result.year_out == YEAR_MIN)) ||
            ((result.day_out == LEN_31) && (result.month_out == MONTH_DEC) &&
             (result.year_out == YEAR_MAX)))
        else $error("saturated result not at a calendar end");

endmodule
